>>> design/ipv6_text_address_parser_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define IPAT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle during reset.
`define IPAT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ipat_pkg.sv
`timescale 1ns / 1ps
package ipat_pkg;

  localparam int unsigned GroupCount = 8;
  localparam int unsigned GidxW      = $clog2(GroupCount);
  localparam int unsigned GroupW     = 16;
  localparam int unsigned NibW       = 4;
  localparam int unsigned HexLetBase = 10;
  localparam int unsigned BankCount  = 2;
  localparam int unsigned BankW      = $clog2(BankCount);
  localparam int unsigned AddrW      = BankW + GidxW;
  localparam int unsigned Depth      = BankCount * GroupCount;

  localparam logic [7:0]       CharColon = 8'h3A;
  localparam logic [7:0]       CharZero  = 8'h30;
  localparam logic [7:0]       CharNine  = 8'h39;
  localparam logic [7:0]       CharLowA  = 8'h61;
  localparam logic [7:0]       CharLowF  = 8'h66;
  localparam logic [7:0]       CharUpA   = 8'h41;
  localparam logic [7:0]       CharUpF   = 8'h46;
  localparam logic [GidxW-1:0] GidxMax   = GidxW'(GroupCount - 1);

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] val;
  } digit_t;

  // Finished string handed from the parser to the drain side.
  typedef struct packed {
    logic             valid;
    logic [BankW-1:0] bank;
    logic [GidxW-1:0] cur;
    logic [GidxW-1:0] ca;
    logic             seen;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [GroupW-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [BankW-1:0] bank;
  } bank_clr_t;

  // Decode one character into a hex nibble.
  function automatic digit_t hex_digit(input logic [7:0] ch);
    digit_t d;
    logic [7:0] off;
    d   = '0;
    off = '0;
    if (ch >= CharZero && ch <= CharNine) begin
      off   = ch - CharZero;
      d.ok  = 1'b1;
      d.val = off[NibW-1:0];
    end else if (ch >= CharLowA && ch <= CharLowF) begin
      off   = ch - CharLowA + 8'(HexLetBase);
      d.ok  = 1'b1;
      d.val = off[NibW-1:0];
    end else if (ch >= CharUpA && ch <= CharUpF) begin
      off   = ch - CharUpA + 8'(HexLetBase);
      d.ok  = 1'b1;
      d.val = off[NibW-1:0];
    end
    return d;
  endfunction

endpackage

>>> design/ipat_group_ram.sv
`timescale 1ns / 1ps
module ipat_group_ram
  import ipat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ram_wr_t           wr_i,
  input  bank_clr_t         clr_i,
  input  logic [AddrW-1:0]  rd_a_addr_i,
  output logic [GroupW-1:0] rd_a_data_o,
  input  logic [AddrW-1:0]  rd_b_addr_i,
  output logic [GroupW-1:0] rd_b_data_o
);

  logic [GroupW-1:0] mem [Depth];
  logic [Depth-1:0]  vld_q;
  logic [GroupW-1:0] rd_a_q;
  logic [GroupW-1:0] rd_b_q;

  // Write the group storage
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (clr_i.en) begin
        for (int unsigned i = 0; i < GroupCount; i++) begin
          vld_q[{clr_i.bank, GidxW'(i)}] <= 1'b0;
        end
      end
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // Register both read ports
  always_ff @(posedge clk_i) begin
    rd_a_q <= vld_q[rd_a_addr_i] ? mem[rd_a_addr_i] : '0;
    rd_b_q <= vld_q[rd_b_addr_i] ? mem[rd_b_addr_i] : '0;
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

>>> design/ipat_char_parser.sv
`timescale 1ns / 1ps
module ipat_char_parser
  import ipat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_code_i,
  input  logic                 is_last_i,
  input  logic [BankCount-1:0] bank_busy_i,
  output logic [AddrW-1:0]     rd_addr_o,
  input  logic [GroupW-1:0]    rd_data_i,
  output ram_wr_t              wr_o,
  output job_t                 job_o
);

  logic             accept;
  digit_t           dig;
  logic             is_colon;

  logic [BankW-1:0] bank_q, bank_d;
  logic [GidxW-1:0] cur_q, cur_d;
  logic [GidxW-1:0] ca_q, ca_d;
  logic             seen_q, seen_d;
  logic             prev_q, prev_d;
  logic             start_q, start_d;

  logic             s1_valid_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [NibW-1:0]  s1_nib_q;
  job_t             job_q, job_d;

  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [GroupW-1:0] fwd_data_q;
  logic [GroupW-1:0] old_val;

  assign in_ready_o = !bank_busy_i[bank_q];
  assign accept     = in_valid_i & in_ready_o;
  assign dig        = hex_digit(char_code_i);
  assign is_colon   = (char_code_i == CharColon);
  assign rd_addr_o  = {bank_q, cur_q};

  // Update the per-string parse state and build the job on the last character
  always_comb begin
    bank_d  = bank_q;
    cur_d   = cur_q;
    ca_d    = ca_q;
    seen_d  = seen_q;
    prev_d  = prev_q;
    start_d = start_q;
    job_d   = '0;
    if (accept) begin
      if (is_colon) begin
        if (prev_q) begin
          ca_d   = cur_q;
          seen_d = 1'b1;
        end else if (!start_q && cur_q != GidxMax) begin
          cur_d = cur_q + GidxW'(1);
        end
        prev_d = 1'b1;
      end else begin
        prev_d = 1'b0;
      end
      start_d = 1'b0;
      if (is_last_i) begin
        job_d.valid = 1'b1;
        job_d.bank  = bank_q;
        job_d.cur   = cur_d;
        job_d.ca    = ca_d;
        job_d.seen  = seen_d;
        bank_d      = bank_q + BankW'(1);
        cur_d       = '0;
        ca_d        = '0;
        seen_d      = 1'b0;
        prev_d      = 1'b0;
        start_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= '0;
      cur_q       <= '0;
      ca_q        <= '0;
      seen_q      <= 1'b0;
      prev_q      <= 1'b0;
      start_q     <= 1'b1;
      s1_valid_q  <= 1'b0;
      job_q       <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      bank_q      <= bank_d;
      cur_q       <= cur_d;
      ca_q        <= ca_d;
      seen_q      <= seen_d;
      prev_q      <= prev_d;
      start_q     <= start_d;
      s1_valid_q  <= accept & dig.ok;
      job_q       <= job_d;
      fwd_valid_q <= wr_o.en;
    end
  end

  // Hold the digit until the group read returns
  always_ff @(posedge clk_i) begin
    s1_addr_q  <= rd_addr_o;
    s1_nib_q   <= dig.val;
    fwd_addr_q <= wr_o.addr;
    fwd_data_q <= wr_o.data;
  end

  // Forward a write from the previous cycle to the same group
  assign old_val = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rd_data_i;

  // Shift the nibble in and write the group back
  assign wr_o.en   = s1_valid_q;
  assign wr_o.addr = s1_addr_q;
  assign wr_o.data = {old_val[GroupW-NibW-1:0], s1_nib_q};

  assign job_o = job_q;

endmodule

>>> design/ipat_group_drain.sv
`timescale 1ns / 1ps
module ipat_group_drain
  import ipat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  job_t                 job_i,
  output logic [BankCount-1:0] bank_busy_o,
  output logic [AddrW-1:0]     rd_addr_o,
  input  logic [GroupW-1:0]    rd_data_i,
  output bank_clr_t            clr_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [GidxW-1:0]     group_index_o,
  output logic [GroupW-1:0]    group_value_o,
  output logic                 last_group_o
);

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  logic [BankCount-1:0] busy_q;
  job_t                 meta_q [BankCount];
  logic [BankW-1:0]     dbank_q;
  logic [GidxW-1:0]     k_q;

  logic                 infl_q;
  logic [GidxW-1:0]     s_k_q;
  logic                 s_zero_q;

  logic [GidxW-1:0]     fifo_idx [FifoDepth];
  logic [GroupW-1:0]    fifo_val [FifoDepth];
  logic [PtrW-1:0]      wptr_q;
  logic [PtrW-1:0]      rptr_q;
  logic [CntW-1:0]      cnt_q;

  job_t                 meta;
  logic [GidxW-1:0]     zfill;
  logic [GidxW:0]       zend;
  logic                 in_zero;
  logic [GidxW-1:0]     src;
  logic                 pop;
  logic                 push;
  logic [CntW:0]        occ;
  logic                 issue;
  logic                 k_end;

  // Map the output group to its source group
  assign meta  = meta_q[dbank_q];
  assign zfill = GidxMax - meta.cur;
  assign zend  = {1'b0, meta.ca} + {1'b0, zfill};
  always_comb begin
    in_zero = 1'b0;
    src     = k_q;
    if (meta.seen && k_q >= meta.ca) begin
      if ({1'b0, k_q} < zend) begin
        in_zero = 1'b1;
      end else begin
        src = k_q - zfill;
      end
    end
  end

  // Issue a read only when the output buffer has room for it
  assign pop   = out_valid_o & out_ready_i;
  assign push  = infl_q;
  assign occ   = (CntW + 1)'(cnt_q) + (CntW + 1)'(infl_q) - (CntW + 1)'(pop);
  assign issue = busy_q[dbank_q] && (occ < (CntW + 1)'(FifoDepth));
  assign k_end = (k_q == GidxMax);

  assign rd_addr_o   = {dbank_q, src};
  assign clr_o.en    = issue & k_end;
  assign clr_o.bank  = dbank_q;
  assign bank_busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      dbank_q <= '0;
      k_q     <= '0;
      infl_q  <= 1'b0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      // Take a finished string from the parser
      if (job_i.valid) begin
        busy_q[job_i.bank] <= 1'b1;
      end
      // Advance the group counter; release the bank after its last group
      if (issue) begin
        k_q <= k_q + GidxW'(1);
        if (k_end) begin
          busy_q[dbank_q] <= 1'b0;
          dbank_q         <= dbank_q + BankW'(1);
        end
      end
      infl_q <= issue;
      if (push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  // Hold the string parameters and the in-flight read tags
  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      meta_q[job_i.bank] <= job_i;
    end
    s_k_q    <= k_q;
    s_zero_q <= in_zero;
    if (push) begin
      fifo_idx[wptr_q] <= s_k_q;
      fifo_val[wptr_q] <= s_zero_q ? '0 : rd_data_i;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign group_index_o = fifo_idx[rptr_q];
  assign group_value_o = fifo_val[rptr_q];
  assign last_group_o  = (fifo_idx[rptr_q] == GidxMax);

endmodule

>>> design/ipv6_text_address_parser.sv
// Output: the job of an address is registered once its last character is taken; its groups
// are read into an output buffer and leave one group per cycle while the output is ready.
// Throughput: one character per cycle; each address yields eight output groups, drained from a
// two-bank group memory, so input stalls only when both banks wait to be drained.
// Reset: asynchronous, active low; clears parse state, bank flags and entry valid bits.
`timescale 1ns / 1ps
module ipv6_text_address_parser
  import ipat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [GidxW-1:0]  group_index_o,
  output logic [GroupW-1:0] group_value_o,
  output logic              last_group_o
);

  logic [BankCount-1:0] bank_busy;
  logic [AddrW-1:0]     rd_a_addr;
  logic [GroupW-1:0]    rd_a_data;
  logic [AddrW-1:0]     rd_b_addr;
  logic [GroupW-1:0]    rd_b_data;
  ram_wr_t              wr;
  bank_clr_t            clr;
  job_t                 job;

  ipat_group_ram u_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .clr_i       (clr),
    .rd_a_addr_i (rd_a_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_addr_i (rd_b_addr),
    .rd_b_data_o (rd_b_data)
  );

  ipat_char_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .bank_busy_i (bank_busy),
    .rd_addr_o   (rd_a_addr),
    .rd_data_i   (rd_a_data),
    .wr_o        (wr),
    .job_o       (job)
  );

  ipat_group_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job),
    .bank_busy_o   (bank_busy),
    .rd_addr_o     (rd_b_addr),
    .rd_data_i     (rd_b_data),
    .clr_o         (clr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .group_index_o (group_index_o),
    .group_value_o (group_value_o),
    .last_group_o  (last_group_o)
  );

endmodule

>>> design/ipat_checker.sv
`timescale 1ns / 1ps
`include "ipv6_text_address_parser_assert.svh"
module ipat_checker
  import ipat_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [GidxW-1:0]  group_index_o,
  input logic [GroupW-1:0] group_value_o,
  input logic              last_group_o
);

  // Hold a stalled result
  `IPAT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(group_index_o) && $stable(group_value_o) && $stable(last_group_o), "output changed while stalled")

  // Flag the final group exactly at the top index
  `IPAT_ASSERT_NOW(a_last_idx, out_valid_o, last_group_o == (group_index_o == GidxMax), "last flag does not match group index")

  // Start a new address at group zero after a final group
  `IPAT_ASSERT_NEXT(a_restart, out_valid_o && out_ready_i && last_group_o, !out_valid_o || group_index_o == '0, "address does not start at group zero")

  // Step the group index by one within an address
  `IPAT_ASSERT_NEXT(a_step, out_valid_o && out_ready_i && !last_group_o, !out_valid_o || group_index_o == GidxW'($past(group_index_o) + GidxW'(1)), "group index skipped")

endmodule

bind ipv6_text_address_parser ipat_checker u_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import ipat_pkg::*;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    logic [GidxW-1:0]  idx;
    logic [GroupW-1:0] val;
    logic              last;
  } group_t;

  // Parse the character stream and queue the expanded groups of each address.
  class group_expander;
    logic [GroupW-1:0] grp[GroupCount];
    logic [GidxW-1:0]  cur;
    logic [GidxW-1:0]  comp_at;
    logic              comp_seen;
    logic              after_colon;
    logic              fresh;
    group_t            groups_due[$];
    int                mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (grp[k]) grp[k] = '0;
      cur         = '0;
      comp_at     = '0;
      comp_seen   = 1'b0;
      after_colon = 1'b0;
      fresh       = 1'b1;
    endfunction

    function void take_char(logic [7:0] ch, logic last);
      int dv;
      int z;
      group_t g;
      dv = 16;
      if (ch >= CharZero && ch <= CharNine) dv = int'(ch - CharZero);
      else if (ch >= CharLowA && ch <= CharLowF) dv = int'(ch - CharLowA) + HexLetBase;
      else if (ch >= CharUpA && ch <= CharUpF) dv = int'(ch - CharUpA) + HexLetBase;

      if (ch == CharColon) begin
        // a second colon marks the zero run, a lone one moves to the next group
        if (after_colon) begin
          comp_at   = cur;
          comp_seen = 1'b1;
        end else if (!fresh && cur != GidxMax) begin
          cur = cur + 1'b1;
        end
        after_colon = 1'b1;
      end else begin
        if (dv < 16) grp[cur] = {grp[cur][GroupW-NibW-1:0], NibW'(dv)};
        after_colon = 1'b0;
      end
      fresh = 1'b0;

      if (last) begin
        // expand the zero run and emit all eight groups
        z = int'(GidxMax) - int'(cur);
        for (int k = 0; k < GroupCount; k++) begin
          if (!comp_seen || k < int'(comp_at)) g.val = grp[k];
          else if (k < int'(comp_at) + z) g.val = '0;
          else g.val = grp[k - z];
          g.idx  = GidxW'(k);
          g.last = (k == GroupCount - 1);
          groups_due.push_back(g);
        end
        clear();
      end
    endfunction

    function void check_group(logic [GidxW-1:0] idx, logic [GroupW-1:0] val, logic last);
      group_t e;
      if (groups_due.size() == 0) begin
        $display("%0t: unexpected group index=%0d value=%h last=%b", $time, idx, val, last);
        mismatches++;
        return;
      end
      e = groups_due.pop_front();
      if (idx !== e.idx || val !== e.val || last !== e.last) begin
        $display("%0t: group mismatch expected index=%0d value=%h last=%b,",
                 $time, e.idx, e.val, e.last);
        $display("%0t:   got index=%0d value=%h last=%b", $time, idx, val, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        char_code_i = '0;
  logic              is_last_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [GidxW-1:0]  group_index_o;
  logic [GroupW-1:0] group_value_o;
  logic              last_group_o;

  int            idle_pct  = 0;
  int            stall_pct = 0;
  bit            hold_req  = 1'b0;
  int            hold_left = 0;
  group_expander board     = new();

  ipv6_text_address_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .group_index_o (group_index_o),
    .group_value_o (group_value_o),
    .last_group_o  (last_group_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Note input transfers and check output transfers mid-cycle, where both sides are stable.
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.take_char(char_code_i, is_last_i);
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_group(group_index_o, group_value_o, last_group_o);
  end

  // Drive output ready: random stalls, or a long hold when asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one character, with random idle cycles ahead of it, and hold it until transfer.
  task automatic send_char(input logic [7:0] ch, input logic last);
    bit took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    is_last_i   <= last;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic send_seq(input text_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_seq(q);
  endtask

  // Build one address: mostly well formed with random content, some raw noise.
  function automatic text_q_t make_addr();
    text_q_t q;
    int ngrp;
    int cpos;
    int ndig;
    int nib;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(3) == 0) q.push_back(CharColon);
        else q.push_back(8'($urandom_range(255)));
      end
    end else begin
      ngrp = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
      cpos = ($urandom_range(99) < 40) ? $urandom_range(0, ngrp) : -1;
      if (cpos != 0 && $urandom_range(9) == 0) q.push_back(CharColon);
      for (int g = 0; g < ngrp; g++) begin
        if (g == cpos) begin
          q.push_back(CharColon);
          q.push_back(CharColon);
          if ($urandom_range(19) == 0) q.push_back(CharColon);
        end else if (g > 0) begin
          q.push_back(CharColon);
        end
        ndig = ($urandom_range(7) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
        repeat (ndig) begin
          nib = $urandom_range(15);
          if (nib < HexLetBase) q.push_back(CharZero + 8'(nib));
          else if ($urandom_range(1)) q.push_back(CharLowA + 8'(nib - HexLetBase));
          else q.push_back(CharUpA + 8'(nib - HexLetBase));
        end
        if ($urandom_range(29) == 0) q.push_back(8'($urandom_range(255)));
      end
      if (cpos == ngrp) begin
        q.push_back(CharColon);
        q.push_back(CharColon);
      end
    end
    if (q.size() == 0) q.push_back(CharZero);
    return q;
  endfunction

  initial begin
    int sent;
    text_q_t q;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, bare zero run, triple colon with a stray letter,
    // long group, full group and an embedded zero run.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("::");
    send_text("a:::G");
    send_text("12345");
    send_text("ffFF::9F");

    // Random addresses under each idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      sent = 0;
      while (sent < 100) begin
        q = make_addr();
        send_seq(q);
        sent += q.size();
      end

      // Back-pressure: hold the output off while short addresses keep coming.
      if (ph == 2) begin
        idle_pct   = 0;
        stall_pct  = 0;
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        hold_req = 1'b1;
        @(posedge clk_i);
        for (int i = 0; i < 12; i++) begin
          if (i % 2) send_text("::");
          else send_text("a::1");
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain what is still owed, then wait for stray output.
    while (board.groups_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("[ipv6_text_address_parser] OK");
    end else begin
      $display("[ipv6_text_address_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[ipv6_text_address_parser] ERROR");
    $finish;
  end

endmodule

>>> ipv6_text_address_parser.f
+incdir+design
design/ipat_pkg.sv
design/ipat_group_ram.sv
design/ipat_char_parser.sv
design/ipat_group_drain.sv
design/ipv6_text_address_parser.sv
design/ipat_checker.sv
test/tb.sv
